[src/barometer_temp_pressure_compensation_core_assert.svh]
// Assertion macros for the barometer compensation core.
`ifndef BAROMETER_TEMP_PRESSURE_COMPENSATION_CORE_ASSERT_SVH
`define BAROMETER_TEMP_PRESSURE_COMPENSATION_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define BTPC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define BTPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[src/btpc_pkg.sv]
// Package with widths, stage counts and helpers for the barometer compensation core.
`default_nettype none
package btpc_pkg;
    localparam int CAL_W = 48;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_STAGES = 32;

    typedef enum logic [1:0] {
        REG_CAL_T  = 2'd0,
        REG_CAL_PA = 2'd1,
        REG_CAL_PB = 2'd2,
        REG_CAL_PC = 2'd3
    } t_reg_idx;

    // Arithmetic right shift of a 32-bit word.
    function automatic logic [31:0] asr(input logic [31:0] v, input int s);
        asr = 32'($signed(v) >>> s);
    endfunction

    // Sign-extended 16-bit calibration word.
    function automatic logic [31:0] sw(input logic [15:0] w);
        sw = {{16{w[15]}}, w};
    endfunction
endpackage
`default_nettype wire

[src/btpc_divider.sv]
// Pipelined restoring 32-bit unsigned divider, one quotient bit per stage.
`default_nettype none
module btpc_divider #(
    parameter int STAGES = btpc_pkg::DIV_STAGES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [31:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_valid,
    output logic [31:0]      o_quot
);
    logic [STAGES:0]       r_vld;
    logic [31:0]           r_num [STAGES+1];
    logic [31:0]           r_den [STAGES+1];
    logic [31:0]           r_rem [STAGES+1];

    always_comb begin
        r_vld[0] = i_valid;
        r_num[0] = i_num;
        r_den[0] = i_den;
        r_rem[0] = '0;
    end

    // Each stage shifts in one dividend bit and subtracts when it fits.
    for (genvar g = 0; g < STAGES; g++) begin : g_st
        logic [32:0] n_trial;
        logic        n_fit;
        always_comb begin
            n_trial = {r_rem[g], r_num[g][31]};
            n_fit   = n_trial >= {1'b0, r_den[g]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
            end
            if (i_en) begin
                r_rem[g+1] <= n_fit ? 32'(n_trial - {1'b0, r_den[g]}) : n_trial[31:0];
                r_num[g+1] <= {r_num[g][30:0], n_fit};
                r_den[g+1] <= r_den[g];
            end
        end
    end

    assign o_valid = r_vld[STAGES];
    assign o_quot  = r_num[STAGES];
endmodule
`default_nettype wire

[src/barometer_temp_pressure_compensation_core.sv]
// Barometer compensation core: register stages, divider and output register.
//
// Usage: a word on the slave channel carries raw pressure (bits 19:0) and raw
// temperature (bits 39:20). A word on the master channel carries compensated
// temperature (31:0), pressure in pascals (63:32) and a pressure valid flag (64).
// Calibration is to be written through the plain write port only while the
// core is idle; the core itself does not enforce this. The pipeline accepts
// one word per cycle while the output is not stalled; from acceptance to the
// result word it runs through 9 arithmetic stages, a 32-stage divider, 3
// final stages and the output register; the divider resolves one bit per stage.
// The whole pipeline advances when the output register is empty or taken;
// when the receiver stalls, the pipeline holds and s_axis_tready falls, so
// nothing is lost or repeated. Reset clears all valid bits and the
// calibration registers to zero; no result is pending after reset.
`default_nettype none
`include "barometer_temp_pressure_compensation_core_assert.svh"
module barometer_temp_pressure_compensation_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [btpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [btpc_pkg::CAL_W-1:0]     i_cfg_data,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: raw_pressure[19:0], raw_temperature[39:20], zero fill
    input  wire logic [39:0]                    s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // tdata: temperature_centi[31:0], pressure_pa[63:32], pressure_valid[64], zero fill
    output logic [71:0]                         m_axis_tdata
);
    logic [btpc_pkg::CAL_W-1:0] r_cal [4];
    logic en;
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;

    // Calibration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_cal[k] <= '0;
        end else if (i_cfg_we) begin
            r_cal[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_comb begin
        t1 = {16'd0, r_cal[btpc_pkg::REG_CAL_T][15:0]};
        t2 = btpc_pkg::sw(r_cal[btpc_pkg::REG_CAL_T][31:16]);
        t3 = btpc_pkg::sw(r_cal[btpc_pkg::REG_CAL_T][47:32]);
        p1 = {16'd0, r_cal[btpc_pkg::REG_CAL_PA][15:0]};
        p2 = btpc_pkg::sw(r_cal[btpc_pkg::REG_CAL_PA][31:16]);
        p3 = btpc_pkg::sw(r_cal[btpc_pkg::REG_CAL_PA][47:32]);
        p4 = btpc_pkg::sw(r_cal[btpc_pkg::REG_CAL_PB][15:0]);
        p5 = btpc_pkg::sw(r_cal[btpc_pkg::REG_CAL_PB][31:16]);
        p6 = btpc_pkg::sw(r_cal[btpc_pkg::REG_CAL_PB][47:32]);
        p7 = btpc_pkg::sw(r_cal[btpc_pkg::REG_CAL_PC][15:0]);
        p8 = btpc_pkg::sw(r_cal[btpc_pkg::REG_CAL_PC][31:16]);
        p9 = btpc_pkg::sw(r_cal[btpc_pkg::REG_CAL_PC][47:32]);
    end

    // Pipeline advances whenever the output register can take a word.
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic [8:0] r_v;
    logic [19:0] r_adcp [7];
    logic [31:0] r_ta, r_td, r_tb, r_fine, r_temp [4:9];
    logic [31:0] r_a, r_q, r_b6, r_b5, r_bsum, r_boff, r_a3, r_a2, r_asum, r_ap1, r_div;
    logic [31:0] r_pbase, r_p3125;
    logic [31:0] r_tmp1;

    // Stages 1 to 9: up to three multiplies per stage, values wrap at 32 bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[7:0], s_axis_tvalid};
        end
        if (en) begin
            r_adcp[0] <= s_axis_tdata[19:0];
            for (int k = 1; k < 7; k++) r_adcp[k] <= r_adcp[k-1];
            // Stage 1: temperature first terms.
            r_ta <= 32'((32'(s_axis_tdata[39:23]) - (t1 << 1)) * t2);
            r_td <= 32'(s_axis_tdata[39:24]) - t1;
            // Stage 2.
            r_tmp1 <= r_ta;
            r_tb   <= 32'(r_td * r_td);
            // Stage 3: fine temperature.
            r_fine <= btpc_pkg::asr(r_tmp1, 11)
                    + btpc_pkg::asr(32'(btpc_pkg::asr(r_tb, 12) * t3), 14);
            // Stage 4: temperature and pressure offset base.
            r_temp[4] <= btpc_pkg::asr(32'(r_fine * 32'd5) + 32'd128, 8);
            r_a <= btpc_pkg::asr(r_fine, 1) - 32'd64000;
            // Stage 5.
            r_q  <= 32'(btpc_pkg::asr(r_a, 2) * btpc_pkg::asr(r_a, 2));
            r_b5 <= 32'(r_a * p5);
            r_a2 <= btpc_pkg::asr(32'(p2 * r_a), 1);
            // Stage 6.
            r_b6 <= 32'(btpc_pkg::asr(r_q, 11) * p6);
            r_a3 <= btpc_pkg::asr(32'(p3 * btpc_pkg::asr(r_q, 13)), 3);
            r_bsum <= r_b5;
            r_asum <= r_a2;
            // Stage 7.
            r_boff <= btpc_pkg::asr(r_b6 + (r_bsum << 1), 2) + (p4 << 16);
            r_ap1  <= 32'd32768 + btpc_pkg::asr(r_a3 + r_asum, 18);
            // Stage 8: divisor.
            r_div   <= btpc_pkg::asr(32'(r_ap1 * p1), 15);
            r_pbase <= (32'd1048576 - 32'(r_adcp[6])) - btpc_pkg::asr(r_boff, 12);
            // Stage 9: scaled dividend.
            r_p3125 <= 32'(r_pbase * 32'd3125);
            r_temp[5] <= r_temp[4];
            r_temp[6] <= r_temp[5];
            r_temp[7] <= r_temp[6];
            r_temp[8] <= r_temp[7];
            r_temp[9] <= r_temp[8];
        end
    end

    // The divisor is registered once more so that it travels alongside r_p3125.
    logic [31:0] r_div9;
    always_ff @(posedge i_clk) begin
        if (en) r_div9 <= r_div;
    end

    logic       big;
    logic [31:0] dnum;
    assign big  = r_p3125[31];
    assign dnum = big ? r_p3125 : (r_p3125 << 1);

    // Side data delayed alongside the divider.
    localparam int DS = btpc_pkg::DIV_STAGES;
    logic [DS-1:0] r_sbig, r_sval;
    logic [31:0]   r_stemp [DS];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sbig[0]  <= big;
            r_sval[0]  <= r_div9 != 32'd0;
            r_stemp[0] <= r_temp[9];
            for (int k = 1; k < DS; k++) begin
                r_sbig[k]  <= r_sbig[k-1];
                r_sval[k]  <= r_sval[k-1];
                r_stemp[k] <= r_stemp[k-1];
            end
        end
    end

    logic dv;
    logic [31:0] dq;
    btpc_divider #(.STAGES(DS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v[8]),
        .i_num(dnum), .i_den(r_div9), .o_valid(dv), .o_quot(dq)
    );

    // Final stages: correction polynomial on the quotient.
    logic [2:0] r_fv;
    logic [31:0] r_p [3], r_ft [3];
    logic [2:0] r_fok;
    logic [31:0] r_fq, r_fb, r_fa;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (en) begin
            r_fv <= {r_fv[1:0], dv};
        end
        if (en) begin
            r_p[0]   <= r_sval[DS-1] ? (r_sbig[DS-1] ? (dq << 1) : dq) : 32'd0;
            r_fok[0] <= r_sval[DS-1];
            r_ft[0]  <= r_stemp[DS-1];
            for (int k = 1; k < 3; k++) begin
                r_p[k] <= r_p[k-1]; r_fok[k] <= r_fok[k-1]; r_ft[k] <= r_ft[k-1];
            end
            r_fq <= 32'((r_p[0] >> 3) * (r_p[0] >> 3));
            r_fb <= btpc_pkg::asr(32'((r_p[0] >> 2) * p8), 13);
            r_fa <= btpc_pkg::asr(32'(p9 * (r_fq >> 13)), 12) + r_fb + p7;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (en) begin
            m_axis_tvalid <= r_fv[2];
        end
        if (en) begin
            m_axis_tdata <= {7'd0, r_fok[2],
                r_fok[2] ? r_p[2] + btpc_pkg::asr(r_fa, 4) : 32'd0, r_ft[2]};
        end
    end

    `BTPC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")
    `BTPC_ASSERT_IMPL(a_ready, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready,
        "input stalled with empty output")
    `BTPC_ASSERT_IMPL(a_flag, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[64],
        m_axis_tdata[63:32] == 32'd0, "pressure nonzero with zero divisor")
endmodule
`default_nettype wire
